/* sv/brb_pkg.sv */
// Shared types and constants of the branch resolve buffer.
// Depends on nothing; every other file but brb_checker refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int WORD_W     = 32;
    localparam int COND_W     = 3;
    localparam int WB_TAG_W   = 6;
    // Widest reorder tag the block supports; narrower tags sit in the low bits.
    localparam int TAG_MAX_W  = 8;
    localparam int FIFO_DEPTH = 2;
    localparam logic [WORD_W-1:0] SEQ_STEP = 32'd4;

    // The six RV32 branch conditions, in the block's own encoding; other codes are never taken.
    typedef enum logic [COND_W-1:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_LT  = 3'd2,
        COND_GE  = 3'd3,
        COND_LTU = 3'd4,
        COND_GEU = 3'd5
    } t_cond;

    // Resolved branch word handed from the front to the back.
    typedef struct packed {
        logic                 dispatch;
        logic [WORD_W-1:0]    pc_from;
        logic [WORD_W-1:0]    target;
        logic [TAG_MAX_W-1:0] tag;
        logic                 squash;
        logic [TAG_MAX_W-1:0] squash_tag;
    } t_entry;

endpackage

`default_nettype wire

/* sv/brb_if.sv */
// Valid/ready channel interfaces of the branch resolve buffer.
// Depends on brb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface brb_in_if #(
    parameter int TAG_BITS = 6
);
    logic                             valid;
    logic                             ready;
    logic                             dispatch_valid;
    logic [brb_pkg::WORD_W-1:0]       src_a;
    logic [brb_pkg::WORD_W-1:0]       src_b;
    logic [brb_pkg::WORD_W-1:0]       branch_pc;
    logic [brb_pkg::WORD_W-1:0]       offset;
    logic [brb_pkg::COND_W-1:0]       cond;
    logic [TAG_BITS-1:0]              entry_tag;
    logic                             squash_valid;
    logic [TAG_BITS-1:0]              squash_tag;

    modport source (
        output valid, dispatch_valid, src_a, src_b, branch_pc, offset, cond,
               entry_tag, squash_valid, squash_tag,
        input  ready
    );
    modport sink (
        input  valid, dispatch_valid, src_a, src_b, branch_pc, offset, cond,
               entry_tag, squash_valid, squash_tag,
        output ready
    );
endinterface

interface brb_out_if;
    logic                             valid;
    logic                             ready;
    logic                             wb_valid;
    logic [brb_pkg::WORD_W-1:0]       wb_pc_from;
    logic [brb_pkg::WORD_W-1:0]       wb_target;
    logic [brb_pkg::WB_TAG_W-1:0]     wb_tag;
    logic                             push_dropped;

    modport source (
        output valid, wb_valid, wb_pc_from, wb_target, wb_tag, push_dropped,
        input  ready
    );
    modport sink (
        input  valid, wb_valid, wb_pc_from, wb_target, wb_tag, push_dropped,
        output ready
    );
endinterface

`default_nettype wire

/* sv/brb_front.sv */
// Front stage: accepts input words, evaluates the branch condition and target.
// Depends on brb_pkg and brb_in_if.
`timescale 1ns / 1ps
`default_nettype none

module brb_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    brb_in_if.sink               i_in,
    output brb_pkg::t_entry      o_entry,
    output logic                 o_valid,
    input  wire logic            i_ready
);

    localparam int TW = brb_pkg::TAG_MAX_W;

    logic            r_valid;
    brb_pkg::t_entry r_entry;
    brb_pkg::t_entry n_entry;
    logic            taken;
    logic            accept;

    // Take a new word whenever the stage is empty or drains this cycle
    assign i_in.ready = !r_valid || i_ready;
    assign accept     = i_in.valid && i_in.ready;

    // Evaluate the condition and form the next pc
    always_comb begin
        case (brb_pkg::t_cond'(i_in.cond))
            brb_pkg::COND_EQ:  taken = (i_in.src_a == i_in.src_b);
            brb_pkg::COND_NE:  taken = (i_in.src_a != i_in.src_b);
            brb_pkg::COND_LT:  taken = ($signed(i_in.src_a) < $signed(i_in.src_b));
            brb_pkg::COND_GE:  taken = !($signed(i_in.src_a) < $signed(i_in.src_b));
            brb_pkg::COND_LTU: taken = (i_in.src_a < i_in.src_b);
            brb_pkg::COND_GEU: taken = (i_in.src_a >= i_in.src_b);
            default:           taken = 1'b0;
        endcase
        n_entry.dispatch   = i_in.dispatch_valid;
        n_entry.pc_from    = i_in.branch_pc;
        n_entry.target     = taken ? (i_in.branch_pc + i_in.offset)
                                   : (i_in.branch_pc + brb_pkg::SEQ_STEP);
        n_entry.tag        = TW'(i_in.entry_tag);
        n_entry.squash     = i_in.squash_valid;
        n_entry.squash_tag = TW'(i_in.squash_tag);
    end

    // Hold the stage valid until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* sv/brb_fifo.sv */
// Short queue of resolved words between the front and the back.
// Depends on brb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brb_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire brb_pkg::t_entry i_entry,
    input  wire logic            i_valid,
    output logic                 o_ready,
    output brb_pkg::t_entry      o_entry,
    output logic                 o_valid,
    input  wire logic            i_ready
);

    localparam int DEPTH = brb_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    brb_pkg::t_entry    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/brb_back.sv */
// Back stage: slot buffer with insert, oldest write-back and squash.
// Depends on brb_pkg and brb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module brb_back #(
    parameter int BUFFER_SLOTS = 8,
    parameter int TAG_BITS     = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire brb_pkg::t_entry i_entry,
    input  wire logic            i_valid,
    output logic                 o_ready,
    brb_out_if.source            o_wb
);

    localparam int IDX_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int WW    = brb_pkg::WORD_W;
    localparam int OTW   = brb_pkg::WB_TAG_W;

    logic [BUFFER_SLOTS-1:0] r_slot_valid;
    logic [BUFFER_SLOTS-1:0] n_slot_valid;
    logic [WW-1:0]           r_slot_pc  [BUFFER_SLOTS];
    logic [WW-1:0]           r_slot_tgt [BUFFER_SLOTS];
    logic [TAG_BITS-1:0]     r_slot_tag [BUFFER_SLOTS];

    logic [BUFFER_SLOTS-1:0] e_valid;
    logic [TAG_BITS-1:0]     e_tag [BUFFER_SLOTS];
    logic [WW-1:0]           e_pc  [BUFFER_SLOTS];
    logic [WW-1:0]           e_tgt [BUFFER_SLOTS];

    logic                    pop;
    logic                    found;
    logic [IDX_W-1:0]        free_idx;
    logic                    ins;
    logic                    dropped;
    logic                    have;
    logic [IDX_W-1:0]        best;
    logic [TAG_BITS-1:0]     best_tag;
    logic [WW-1:0]           best_pc;
    logic [WW-1:0]           best_tgt;
    logic [TAG_BITS-1:0]     ins_tag;
    logic [TAG_BITS-1:0]     sq_tag;

    logic                    r_out_valid;
    logic                    r_wb_valid;
    logic [WW-1:0]           r_wb_pc;
    logic [WW-1:0]           r_wb_tgt;
    logic [OTW-1:0]          r_wb_tag;
    logic                    r_dropped;

    // Circular age: a is older than b when a - b has its top bit set
    function automatic logic f_older(input logic [TAG_BITS-1:0] a,
                                     input logic [TAG_BITS-1:0] b);
        logic [TAG_BITS-1:0] d;
        d = a - b;
        return d[TAG_BITS-1];
    endfunction

    assign o_ready = !r_out_valid || o_wb.ready;
    assign pop     = i_valid && o_ready;
    assign ins_tag = i_entry.tag[TAG_BITS-1:0];
    assign sq_tag  = i_entry.squash_tag[TAG_BITS-1:0];

    // Place the dispatched branch in the lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            if (!r_slot_valid[i] && !found) begin
                found    = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
        ins     = i_entry.dispatch && found;
        dropped = i_entry.dispatch && !found;
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            if (ins && free_idx == IDX_W'(i)) begin
                e_valid[i] = 1'b1;
                e_tag[i]   = ins_tag;
                e_pc[i]    = i_entry.pc_from;
                e_tgt[i]   = i_entry.target;
            end else begin
                e_valid[i] = r_slot_valid[i];
                e_tag[i]   = r_slot_tag[i];
                e_pc[i]    = r_slot_pc[i];
                e_tgt[i]   = r_slot_tgt[i];
            end
        end
    end

    // Pick the oldest valid slot, lowest index on equal age
    always_comb begin
        have     = 1'b0;
        best     = '0;
        best_tag = '0;
        best_pc  = '0;
        best_tgt = '0;
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            if (e_valid[i] && (!have || f_older(e_tag[i], best_tag))) begin
                have     = 1'b1;
                best     = IDX_W'(i);
                best_tag = e_tag[i];
                best_pc  = e_pc[i];
                best_tgt = e_tgt[i];
            end
        end
    end

    // Free the written-back slot, then drop slots not older than the squash tag
    always_comb begin
        for (int i = 0; i < BUFFER_SLOTS; i++) begin
            n_slot_valid[i] = e_valid[i]
                && !(have && best == IDX_W'(i))
                && !(i_entry.squash && !f_older(e_tag[i], sq_tag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (pop) begin
            r_slot_valid <= n_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && ins) begin
            r_slot_pc[free_idx]  <= i_entry.pc_from;
            r_slot_tgt[free_idx] <= i_entry.target;
            r_slot_tag[free_idx] <= ins_tag;
        end
    end

    // Output register: hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (o_wb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_wb_valid <= have;
            r_wb_pc    <= best_pc;
            r_wb_tgt   <= best_tgt;
            r_wb_tag   <= OTW'(best_tag);
            r_dropped  <= dropped;
        end
    end

    assign o_wb.valid        = r_out_valid;
    assign o_wb.wb_valid     = r_wb_valid;
    assign o_wb.wb_pc_from   = r_wb_pc;
    assign o_wb.wb_target    = r_wb_tgt;
    assign o_wb.wb_tag       = r_wb_tag;
    assign o_wb.push_dropped = r_dropped;

endmodule

`default_nettype wire

/* sv/branch_resolve_buffer.sv */
// Top level of the branch resolve buffer: front, queue and back.
// Depends on brb_pkg, brb_if, brb_front, brb_fifo and brb_back.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one processor cycle: an optional dispatched RV32 branch
// and an optional squash. The front evaluates the condition (EQ, NE, LT, GE,
// LTU, GEU; other codes not taken) and forms the next pc, branch_pc + offset
// or branch_pc + 4. The back places the branch in the lowest free slot, writes
// back the oldest valid slot by circular tag age and frees it, then discards
// every slot whose tag is not older than the squash tag. Every input word
// gives exactly one result word, in order; with nothing to write back the
// result fields read zero. The block takes one word per clock when the sink
// keeps up; a word passes the front register and the queue, and its result
// waits in the output register until the sink takes it. The slot search in the
// back (insert, oldest pick, squash over all slots, combinational) sets the
// clock. A two-word queue between front and back lets either side stall alone.
module branch_resolve_buffer #(
    parameter int BUFFER_SLOTS = 8,
    parameter int TAG_BITS     = 6
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    brb_in_if.sink    i_in,
    brb_out_if.source o_wb
);

    brb_pkg::t_entry front_entry;
    logic            front_valid;
    logic            front_ready;
    brb_pkg::t_entry back_entry;
    logic            back_valid;
    logic            back_ready;

    brb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_entry (front_entry),
        .o_valid (front_valid),
        .i_ready (front_ready)
    );

    brb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (front_entry),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_entry (back_entry),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    brb_back #(
        .BUFFER_SLOTS (BUFFER_SLOTS),
        .TAG_BITS     (TAG_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (back_entry),
        .i_valid (back_valid),
        .o_ready (back_ready),
        .o_wb    (o_wb)
    );

endmodule

`default_nettype wire

/* sv/brb_checker.sv */
// Port-level checks on the branch resolve buffer, bound to the top level.
// Depends only on the top level's port signals.
`timescale 1ns / 1ps
`default_nettype none

module brb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_wb_valid,
    input wire logic        i_wb_ready,
    input wire logic        i_wb_res_valid,
    input wire logic [31:0] i_wb_pc_from,
    input wire logic [31:0] i_wb_target,
    input wire logic [5:0]  i_wb_tag,
    input wire logic        i_push_dropped
);

    logic [2:0] r_outstanding;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_wb_valid && i_wb_ready;

    // Track words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + {2'b00, in_acc} - {2'b00, out_acc};
        end
    end

    // Pipeline holds at most four words, and no result comes without an input
    a_outstanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding <= 3'd4) && (!i_wb_valid || r_outstanding != 3'd0))
        else $error("outstanding word count out of range");

    // Each branch leaves in its own cycle, so the slots never overflow
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wb_valid |-> !i_push_dropped)
        else $error("branch dropped on full buffer");

    // An empty write-back reports zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wb_valid && !i_wb_res_valid) |->
            (i_wb_pc_from == 32'd0 && i_wb_target == 32'd0 && i_wb_tag == 6'd0))
        else $error("empty write-back carries nonzero fields");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wb_valid && !i_wb_ready) |=>
            (i_wb_valid && $stable(i_wb_res_valid) && $stable(i_wb_pc_from)
             && $stable(i_wb_target) && $stable(i_wb_tag)))
        else $error("stalled result changed");

endmodule

bind branch_resolve_buffer brb_checker u_brb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_wb_valid     (o_wb.valid),
    .i_wb_ready     (o_wb.ready),
    .i_wb_res_valid (o_wb.wb_valid),
    .i_wb_pc_from   (o_wb.wb_pc_from),
    .i_wb_target    (o_wb.wb_target),
    .i_wb_tag       (o_wb.wb_tag),
    .i_push_dropped (o_wb.push_dropped)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench of the branch resolve buffer: random and directed
// cycle words, a slot-level predictor and a scoreboard. Depends on brb_pkg, brb_if.
`timescale 1ns / 1ps

module tb;

    localparam int          BUFFER_SLOTS = 8;
    localparam int          TAG_BITS     = 6;
    localparam int          WORD_W       = brb_pkg::WORD_W;
    localparam int          COND_W       = brb_pkg::COND_W;
    localparam int          WB_TAG_W     = brb_pkg::WB_TAG_W;
    localparam int          PHASE_WORDS  = 332;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 400000;
    // Condition codes outside the package enum; never taken.
    localparam logic [COND_W-1:0] COND_RSVD6 = 3'd6;
    localparam logic [COND_W-1:0] COND_RSVD7 = 3'd7;
    localparam logic [WORD_W-1:0] CORNERS [5] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff
    };

    // One processor cycle as seen on the input channel.
    typedef struct {
        logic                dispatch;
        logic [WORD_W-1:0]   src_a;
        logic [WORD_W-1:0]   src_b;
        logic [WORD_W-1:0]   pc;
        logic [WORD_W-1:0]   offset;
        logic [COND_W-1:0]   cond;
        logic [TAG_BITS-1:0] tag;
        logic                squash;
        logic [TAG_BITS-1:0] squash_tag;
    } t_branch_cycle;

    // One write-back word as seen on the output channel.
    typedef struct {
        logic                wb_valid;
        logic [WORD_W-1:0]   pc_from;
        logic [WORD_W-1:0]   target;
        logic [WB_TAG_W-1:0] tag;
        logic                dropped;
    } t_wb_word;

    // Slot-accurate model of the buffer plus the queue of pending write-backs.
    class branch_wb_predictor;
        bit                  slot_valid  [BUFFER_SLOTS];
        logic [WORD_W-1:0]   slot_pc     [BUFFER_SLOTS];
        logic [WORD_W-1:0]   slot_target [BUFFER_SLOTS];
        logic [TAG_BITS-1:0] slot_tag    [BUFFER_SLOTS];
        t_wb_word            pending_wb  [$];
        int                  mismatches;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i]  = 1'b0;
                slot_pc[i]     = '0;
                slot_target[i] = '0;
                slot_tag[i]    = '0;
            end
            mismatches = 0;
        endfunction

        // Circular age: a is older than b when a - b wraps into the upper half.
        function bit tag_older(logic [TAG_BITS-1:0] a, logic [TAG_BITS-1:0] b);
            logic [TAG_BITS-1:0] diff;
            diff = a - b;
            return diff[TAG_BITS-1];
        endfunction

        function bit taken(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                           logic [COND_W-1:0] c);
            case (c)
                brb_pkg::COND_EQ:  return a == b;
                brb_pkg::COND_NE:  return a != b;
                brb_pkg::COND_LT:  return $signed(a) < $signed(b);
                brb_pkg::COND_GE:  return $signed(a) >= $signed(b);
                brb_pkg::COND_LTU: return a < b;
                brb_pkg::COND_GEU: return a >= b;
                default:           return 1'b0;
            endcase
        endfunction

        // Advance the buffer by one accepted cycle word and queue its write-back.
        function void note_cycle(t_branch_cycle w);
            int       free_slot;
            int       oldest;
            t_wb_word res;
            free_slot = -1;
            oldest    = -1;
            res       = '{default: '0};
            // insert into the lowest free slot, or flag the drop
            if (w.dispatch) begin
                for (int i = 0; i < BUFFER_SLOTS; i++) begin
                    if (!slot_valid[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) begin
                    res.dropped = 1'b1;
                end else begin
                    slot_valid[free_slot]  = 1'b1;
                    slot_pc[free_slot]     = w.pc;
                    slot_target[free_slot] = taken(w.src_a, w.src_b, w.cond)
                                             ? w.pc + w.offset
                                             : w.pc + brb_pkg::SEQ_STEP;
                    slot_tag[free_slot]    = w.tag;
                end
            end
            // write back the oldest slot; ties go to the lowest index
            for (int i = 0; i < BUFFER_SLOTS; i++) begin
                if (slot_valid[i] && (oldest < 0 || tag_older(slot_tag[i], slot_tag[oldest])))
                    oldest = i;
            end
            if (oldest >= 0) begin
                res.wb_valid = 1'b1;
                res.pc_from  = slot_pc[oldest];
                res.target   = slot_target[oldest];
                res.tag      = WB_TAG_W'(slot_tag[oldest]);
                slot_valid[oldest] = 1'b0;
            end
            // squash after write-back: drop every slot not older than the squash tag
            if (w.squash) begin
                for (int i = 0; i < BUFFER_SLOTS; i++) begin
                    if (slot_valid[i] && !tag_older(slot_tag[i], w.squash_tag))
                        slot_valid[i] = 1'b0;
                end
            end
            pending_wb.push_back(res);
        endfunction

        function void compare_field(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Match a received write-back word against the oldest expectation.
        function void check_wb(t_wb_word got);
            t_wb_word want;
            if (pending_wb.size() == 0) begin
                $display("%0t: unexpected write-back word, expected none, got pc %h tag %h",
                         $time, got.pc_from, got.tag);
                mismatches++;
                return;
            end
            want = pending_wb.pop_front();
            compare_field("wb_valid", WORD_W'(want.wb_valid), WORD_W'(got.wb_valid));
            compare_field("wb_pc_from", want.pc_from, got.pc_from);
            compare_field("wb_target", want.target, got.target);
            compare_field("wb_tag", WORD_W'(want.tag), WORD_W'(got.tag));
            compare_field("push_dropped", WORD_W'(want.dropped), WORD_W'(got.dropped));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   cycle_count;

    branch_wb_predictor wb_model;

    brb_in_if #(.TAG_BITS(TAG_BITS)) in_ch ();
    brb_out_if                       wb_ch ();

    branch_resolve_buffer #(
        .BUFFER_SLOTS(BUFFER_SLOTS),
        .TAG_BITS    (TAG_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_wb   (wb_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Stall the write-back side at the current phase rate.
    always @(posedge i_clk) begin
        wb_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every accepted write-back word.
    always @(posedge i_clk) begin : wb_monitor
        t_wb_word got;
        if (i_rst_n === 1'b1 && wb_ch.valid === 1'b1 && wb_ch.ready === 1'b1) begin
            got.wb_valid = wb_ch.wb_valid;
            got.pc_from  = wb_ch.wb_pc_from;
            got.target   = wb_ch.wb_target;
            got.tag      = wb_ch.wb_tag;
            got.dropped  = wb_ch.push_dropped;
            wb_model.check_wb(got);
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[branch_resolve_buffer] ERROR");
            $finish;
        end
    end

    function automatic t_branch_cycle make_cycle(
        logic dv, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b, logic [WORD_W-1:0] pc,
        logic [WORD_W-1:0] off, logic [COND_W-1:0] c, logic [TAG_BITS-1:0] tag,
        logic sq, logic [TAG_BITS-1:0] sq_tag);
        t_branch_cycle w;
        w.dispatch   = dv;
        w.src_a      = a;
        w.src_b      = b;
        w.pc         = pc;
        w.offset     = off;
        w.cond       = c;
        w.tag        = tag;
        w.squash     = sq;
        w.squash_tag = sq_tag;
        return w;
    endfunction

    // Random cycle word biased toward operand pairs that split the conditions.
    function automatic t_branch_cycle random_cycle();
        t_branch_cycle w;
        int            pick;
        w.dispatch = ($urandom_range(99) < 85);
        w.src_a    = ($urandom_range(99) < 15) ? CORNERS[$urandom_range(4)] : $urandom();
        pick       = $urandom_range(99);
        if (pick < 25)      w.src_b = w.src_a;
        else if (pick < 40) w.src_b = w.src_a ^ 32'h8000_0000;
        else if (pick < 50) w.src_b = w.src_a + ($urandom_range(1) ? 32'd1 : 32'hffff_ffff);
        else if (pick < 60) w.src_b = CORNERS[$urandom_range(4)];
        else                w.src_b = $urandom();
        w.pc     = ($urandom_range(99) < 10) ? CORNERS[$urandom_range(4)] : $urandom();
        w.offset = ($urandom_range(1) == 1) ? $urandom()
                   : WORD_W'($signed($urandom_range(8190)) - 4096);
        w.cond   = COND_W'($urandom_range(7));
        w.tag    = TAG_BITS'($urandom());
        w.squash = ($urandom_range(99) < 20);
        w.squash_tag = ($urandom_range(3) == 0) ? w.tag : TAG_BITS'($urandom());
        return w;
    endfunction

    // Present one cycle word after random idle cycles; hold until accepted.
    task automatic send_cycle(t_branch_cycle w);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.dispatch_valid <= w.dispatch;
        in_ch.src_a          <= w.src_a;
        in_ch.src_b          <= w.src_b;
        in_ch.branch_pc      <= w.pc;
        in_ch.offset         <= w.offset;
        in_ch.cond           <= w.cond;
        in_ch.entry_tag      <= w.tag;
        in_ch.squash_valid   <= w.squash;
        in_ch.squash_tag     <= w.squash_tag;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        wb_model.note_cycle(w);
    endtask

    task automatic run_phase(int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < PHASE_WORDS; n++) send_cycle(random_cycle());
    endtask

    initial begin
        wb_model             = new();
        idle_pct             = 0;
        stall_pct            = 0;
        cycle_count          = 0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.dispatch_valid = 1'b0;
        in_ch.src_a          = '0;
        in_ch.src_b          = '0;
        in_ch.branch_pc      = '0;
        in_ch.offset         = '0;
        in_ch.cond           = brb_pkg::COND_EQ;
        in_ch.entry_tag      = '0;
        in_ch.squash_valid   = 1'b0;
        in_ch.squash_tag     = '0;
        wb_ch.ready          = 1'b0;

        // hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every condition taken and not taken, unknown codes,
        // signed/unsigned corners, pc wrap, tag and squash corners
        send_cycle(make_cycle(1'b1, 32'h1234_5678, 32'h1234_5678, 32'h0000_1000, 32'h40,
                              brb_pkg::COND_EQ, 6'd0, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h1234_5678, 32'h1234_5679, 32'h0000_1000, 32'h40,
                              brb_pkg::COND_EQ, 6'd1, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h0, 32'h1, 32'h0000_2000, 32'hffff_fff0,
                              brb_pkg::COND_NE, 6'd2, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_2000, 32'h10,
                              brb_pkg::COND_NE, 6'd3, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_3000, 32'h80,
                              brb_pkg::COND_LT, 6'd4, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_3000, 32'h80,
                              brb_pkg::COND_LT, 6'd5, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_4000, 32'h8,
                              brb_pkg::COND_GE, 6'd6, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'hffff_ffff, 32'h0, 32'h0000_4000, 32'h8,
                              brb_pkg::COND_GE, 6'd7, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_5000, 32'h20,
                              brb_pkg::COND_LTU, 6'd8, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'hffff_ffff, 32'h0, 32'h0000_5000, 32'h20,
                              brb_pkg::COND_LTU, 6'd9, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h0, 32'h0, 32'h0000_6000, 32'h1000,
                              brb_pkg::COND_GEU, 6'd10, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h0, 32'hffff_ffff, 32'h0000_6000, 32'h1000,
                              brb_pkg::COND_GEU, 6'd11, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h5, 32'h5, 32'h0000_7000, 32'h100,
                              COND_RSVD6, 6'd12, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h5, 32'h6, 32'h0000_7000, 32'h100,
                              COND_RSVD7, 6'd13, 1'b0, 6'd0));
        // pc + 4 and pc + offset wrap past the top of the address space
        send_cycle(make_cycle(1'b1, 32'h1, 32'h2, 32'hffff_fffc, 32'h8,
                              brb_pkg::COND_EQ, 6'd63, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b1, 32'h1, 32'h1, 32'hffff_fff0, 32'h20,
                              brb_pkg::COND_EQ, 6'd63, 1'b1, 6'd63));
        send_cycle(make_cycle(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              COND_RSVD7, 6'd63, 1'b1, 6'd63));
        // no branch: empty write-back, with and without squash
        send_cycle(make_cycle(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, brb_pkg::COND_EQ,
                              6'd0, 1'b0, 6'd0));
        send_cycle(make_cycle(1'b0, 32'h0, 32'h0, 32'h0, 32'h0, brb_pkg::COND_EQ,
                              6'd0, 1'b1, 6'd0));
        // squash tag equal to, just after and just before the branch tag
        send_cycle(make_cycle(1'b1, 32'h3, 32'h3, 32'h0000_8000, 32'h4,
                              brb_pkg::COND_EQ, 6'd32, 1'b1, 6'd32));
        send_cycle(make_cycle(1'b1, 32'h3, 32'h3, 32'h0000_8000, 32'h4,
                              brb_pkg::COND_EQ, 6'd0, 1'b1, 6'd1));
        send_cycle(make_cycle(1'b1, 32'h3, 32'h3, 32'h0000_8000, 32'h4,
                              brb_pkg::COND_EQ, 6'd0, 1'b1, 6'd63));

        // random phases: none, sender idle, receiver stall, both
        run_phase(0, 0);
        run_phase(47, 0);
        run_phase(0, 47);
        run_phase(13, 13);
        in_ch.valid <= 1'b0;

        // drain outstanding write-backs, then allow the pipeline latency
        while (wb_model.pending_wb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (wb_model.mismatches == 0) begin
            $display("[branch_resolve_buffer] OK");
        end else begin
            $display("[branch_resolve_buffer] ERROR");
        end
        $finish;
    end

endmodule
